// ----- rtl/core/bhl_pkg.sv -----
// Shared types and constants of the bucketed hash table.
// Request, response and bucket row layouts, the mix constants and command codes.
// No dependencies.
package bhl_pkg;

    localparam int DEF_LOG2_BUCKETS = 10;
    localparam int SLOTS            = 4;

    localparam logic [63:0] EMPTY_KEY = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIX_C1    = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic       CMD_LOOKUP  = 1'b0;
    localparam logic       CMD_INSERT  = 1'b1;
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_PLACED = 2'd1;
    localparam logic [1:0] KIND_EVICT  = 2'd2;

    typedef struct packed {
        logic        command;
        logic [63:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [1:0]  insert_kind;
    } t_resp;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] value;
        logic [15:0] count;
    } t_slot;

    typedef t_slot [SLOTS-1:0] t_row;

    localparam t_slot EMPTY_SLOT = '{key: EMPTY_KEY, value: 32'd0, count: 16'd0};
    localparam t_row  EMPTY_ROW  = {SLOTS{EMPTY_SLOT}};
    localparam int    ROW_W      = $bits(t_row);

    typedef struct packed {
        logic        hit;
        logic        place;
        logic [31:0] rd_value;
    } t_dec;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_RESP
    } t_state;

endpackage

// ----- rtl/core/bhl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bhl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bhl_hash.sv -----
// Sequential 64-bit finalizer mix on one shared 32x32 multiplier.
// Eight steps per key; depends on bhl_pkg for the mix constants.
module bhl_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key,
    output logic        o_done,
    output logic [63:0] o_hash
);
    import bhl_pkg::*;

    logic [63:0] r_v, n_v;
    logic [63:0] r_acc, n_acc;
    logic [2:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] mul_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    always_comb begin
        mul_c = r_step[2] ? MIX_C2 : MIX_C1;
        case (r_step[1:0])
            2'd0: begin
                mul_a = r_v[31:0];
                mul_b = mul_c[31:0];
            end
            2'd1: begin
                mul_a = r_v[31:0];
                mul_b = mul_c[63:32];
            end
            default: begin
                mul_a = r_v[63:32];
                mul_b = mul_c[31:0];
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb begin
        n_v    = r_v;
        n_acc  = r_acc;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_v    = i_key ^ (i_key >> 33);
            n_step = 3'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            case (r_step[1:0])
                2'd0:    n_acc = mul_p;
                2'd3:    n_v   = r_acc ^ (r_acc >> 33);
                default: n_acc = {r_acc[63:32] + mul_p[31:0], r_acc[31:0]};
            endcase
            n_step = r_step + 3'd1;
            if (r_step == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_hash = r_v;

endmodule

// ----- rtl/core/bhl_bucket.sv -----
// Bucket decision logic: key match, free or cold slot choice, eviction choice.
// Builds the updated row; depends on bhl_pkg for row and decision types.
module bhl_bucket (
    input  bhl_pkg::t_row  i_row,
    input  logic [63:0]    i_key,
    input  logic [31:0]    i_value,
    input  logic           i_evict,
    output bhl_pkg::t_dec  o_dec,
    output bhl_pkg::t_row  o_row
);
    import bhl_pkg::*;

    logic        hit;
    logic [1:0]  mi;
    logic [1:0]  ci;
    logic [15:0] mf;
    logic        stop;
    logic [1:0]  ei;
    t_row        row;

    always_comb begin
        hit = 1'b0;
        mi  = 2'd0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (i_row[s].key == i_key) begin
                hit = 1'b1;
                mi  = 2'(s);
            end
        end

        ci   = 2'd0;
        mf   = i_row[0].count;
        stop = 1'b0;
        for (int j = 1; j < SLOTS; j++) begin
            if (!stop) begin
                if (i_row[j].key == EMPTY_KEY) begin
                    ci   = 2'(j);
                    mf   = 16'd0;
                    stop = 1'b1;
                end else if (i_row[j].count < mf) begin
                    ci = 2'(j);
                    mf = i_row[j].count;
                end
            end
        end

        ei = 2'd0;
        for (int j = 1; j < SLOTS; j++) begin
            if (i_row[j].count < i_row[ei].count) begin
                ei = 2'(j);
            end
        end

        row = i_row;
        if (i_evict) begin
            row[ei] = '{key: i_key, value: i_value, count: 16'd1};
        end else if (hit) begin
            row[mi].value = i_value;
            row[mi].count = (i_row[mi].count == COUNT_MAX) ? COUNT_MAX
                                                           : i_row[mi].count + 16'd1;
        end else begin
            row[ci] = '{key: i_key, value: i_value, count: 16'd1};
        end

        o_dec.hit      = hit;
        o_dec.place    = (mf < 16'd2);
        o_dec.rd_value = i_row[mi].value;
        o_row          = row;
    end

endmodule

// ----- rtl/core/bucketed_hash_table_lfu.sv -----
// Bucketed hash table with least-frequently-used replacement, four slots per bucket.
// Steps: the key mix (eight multiplier steps), a read and a check of each probed bucket on the
// single RAM read port, and the response load; a reserved (all-ones) key skips the mix and the
// bucket reads and goes straight to the response load.
// A new transaction is taken only once the last response is loaded. Reset clears all
// 2**LOG2_BUCKETS bucket rows, one bucket row per cycle, taking no transaction meanwhile.
module bucketed_hash_table_lfu #(
    parameter int LOG2_BUCKETS = bhl_pkg::DEF_LOG2_BUCKETS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bhl_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bhl_pkg::t_resp o_out_data
);
    import bhl_pkg::*;

    localparam int NUM_BUCKETS = 1 << LOG2_BUCKETS;

    t_state                  r_state, n_state;
    logic [LOG2_BUCKETS-1:0] r_clr_addr, n_clr_addr;
    logic                    r_cmd, n_cmd;
    logic [63:0]             r_key, n_key;
    logic [31:0]             r_value, n_value;
    logic [LOG2_BUCKETS-1:0] r_bucket, n_bucket;
    logic [1:0]              r_probe, n_probe;
    logic                    r_evict, n_evict;
    t_resp                   r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_resp                   r_out, n_out;

    logic                    in_acc;
    logic                    hash_start;
    logic                    hash_done;
    logic [63:0]             hash_val;
    logic [LOG2_BUCKETS-1:0] probe_addr;
    logic                    ram_we;
    logic                    ram_re;
    logic [LOG2_BUCKETS-1:0] ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;
    logic [ROW_W-1:0]        ram_rdata;
    t_dec                    dec;
    t_row                    new_row;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign hash_start = in_acc && (i_in_data.key != EMPTY_KEY);
    assign probe_addr = r_bucket + LOG2_BUCKETS'(r_probe);

    bhl_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_in_data.key),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    bhl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (probe_addr),
        .o_rdata (ram_rdata)
    );

    bhl_bucket u_bucket (
        .i_row   (t_row'(ram_rdata)),
        .i_key   (r_key),
        .i_value (r_value),
        .i_evict (r_evict),
        .o_dec   (dec),
        .o_row   (new_row)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_value     = r_value;
        n_bucket    = r_bucket;
        n_probe     = r_probe;
        n_evict     = r_evict;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = probe_addr;
        ram_wdata   = ROW_W'(new_row);

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = ROW_W'(EMPTY_ROW);
                n_clr_addr = r_clr_addr + LOG2_BUCKETS'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_in_data.command;
                    n_key   = i_in_data.key;
                    n_value = i_in_data.value;
                    n_res   = '0;
                    if (i_in_data.key == EMPTY_KEY) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_bucket = hash_val[LOG2_BUCKETS-1:0];
                    n_probe  = 2'd0;
                    n_evict  = 1'b0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_READ;
                n_probe = r_probe + 2'd1;
                if (r_cmd == CMD_LOOKUP) begin
                    if (dec.hit) begin
                        n_res   = '{hit: 1'b1, read_value: dec.rd_value, insert_kind: KIND_UPDATE};
                        n_state = S_RESP;
                    end else if (r_probe == 2'd3) begin
                        n_state = S_RESP;
                    end
                end else if (r_evict) begin
                    ram_we            = 1'b1;
                    n_res.insert_kind = KIND_EVICT;
                    n_state           = S_RESP;
                end else if (dec.hit) begin
                    ram_we            = 1'b1;
                    n_res.hit         = 1'b1;
                    n_res.insert_kind = KIND_UPDATE;
                    n_state           = S_RESP;
                end else if (dec.place) begin
                    ram_we            = 1'b1;
                    n_res.insert_kind = KIND_PLACED;
                    n_state           = S_RESP;
                end else if (r_probe == 2'd3) begin
                    n_evict = 1'b1;
                    n_probe = 2'd0;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_value  <= n_value;
        r_bucket <= n_bucket;
        r_probe  <= n_probe;
        r_evict  <= n_evict;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    a_lookup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && r_cmd == CMD_LOOKUP) |-> !ram_we)
        else $error("lookup wrote the table");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("transaction taken during clearing pass");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("response loaded outside response state");
`endif

endmodule

// ----- test/bucketed_hash_table_lfu_check.sv -----
// Checker for the bucketed hash table: watches both channels, keeps its own copy of the
// table, predicts each response and compares it with what the block returns.
// Depends on bhl_pkg for the request and response types and the table constants.
module bucketed_hash_table_lfu_check #(
    parameter int LOG2_BUCKETS = bhl_pkg::DEF_LOG2_BUCKETS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  bhl_pkg::t_req  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  bhl_pkg::t_resp i_out_data,
    output int             o_errors,
    output int             o_pending
);
    import bhl_pkg::*;

    localparam int ENTRIES    = SLOTS << LOG2_BUCKETS;
    localparam int PRINT_CAP  = 40;

    logic [63:0] tbl_key   [ENTRIES];
    logic [31:0] tbl_value [ENTRIES];
    logic [15:0] tbl_count [ENTRIES];

    t_resp expected_resp_q[$];
    int    mismatch_count = 0;
    int    pending_count  = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;

    initial begin : clear_table
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            tbl_key[i]   = EMPTY_KEY;
            tbl_value[i] = '0;
            tbl_count[i] = '0;
        end
    end

    function automatic logic [63:0] finalize_hash(input logic [63:0] k);
        logic [63:0] x;
        x = k ^ (k >> 33);
        x = x * MIX_C1;
        x = x ^ (x >> 33);
        x = x * MIX_C2;
        x = x ^ (x >> 33);
        return x;
    endfunction

    function automatic int find_slot(input int base, input logic [63:0] k);
        int s;
        for (s = 0; s < SLOTS; s++) begin
            if (tbl_key[base + s] == k) return s;
        end
        return -1;
    endfunction

    task automatic write_slot(input int e, input logic [63:0] k, input logic [31:0] v);
        tbl_key[e]   = k;
        tbl_value[e] = v;
        tbl_count[e] = 16'd1;
    endtask

    task automatic apply_request(input t_req req, output t_resp resp);
        logic [63:0]             h;
        logic [LOG2_BUCKETS-1:0] bkt;
        logic [15:0]             low_count;
        logic                    done;
        int                      base;
        int                      hit_slot;
        int                      pick;
        int                      r;
        int                      j;
        resp = '0;
        if (req.key != EMPTY_KEY) begin
            h    = finalize_hash(req.key);
            done = 1'b0;
            for (r = 0; r < 4 && !done; r++) begin
                bkt      = h[LOG2_BUCKETS-1:0] + LOG2_BUCKETS'(r);
                base     = SLOTS * int'(bkt);
                hit_slot = find_slot(base, req.key);
                if (hit_slot >= 0) begin
                    resp.hit = 1'b1;
                    done     = 1'b1;
                    if (req.command == CMD_LOOKUP) begin
                        resp.read_value = tbl_value[base + hit_slot];
                    end else begin
                        tbl_value[base + hit_slot] = req.value;
                        if (tbl_count[base + hit_slot] != COUNT_MAX)
                            tbl_count[base + hit_slot] = tbl_count[base + hit_slot] + 16'd1;
                        resp.insert_kind = KIND_UPDATE;
                    end
                end else if (req.command == CMD_INSERT) begin
                    pick      = 0;
                    low_count = tbl_count[base];
                    for (j = 1; j < SLOTS; j++) begin
                        if (tbl_key[base + j] == EMPTY_KEY) begin
                            pick      = j;
                            low_count = '0;
                            break;
                        end
                        if (tbl_count[base + j] < low_count) begin
                            pick      = j;
                            low_count = tbl_count[base + j];
                        end
                    end
                    if (low_count < 16'd2) begin
                        write_slot(base + pick, req.key, req.value);
                        resp.insert_kind = KIND_PLACED;
                        done             = 1'b1;
                    end
                end
            end
            if (!done && req.command == CMD_INSERT) begin
                bkt  = h[LOG2_BUCKETS-1:0];
                base = SLOTS * int'(bkt);
                pick = 0;
                for (j = 1; j < SLOTS; j++) begin
                    if (tbl_count[base + j] < tbl_count[base + pick]) pick = j;
                end
                write_slot(base + pick, req.key, req.value);
                resp.insert_kind = KIND_EVICT;
            end
        end
    endtask

    task automatic check_resp(input t_resp want, input t_resp got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
                if (got.hit !== want.hit)
                    $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
                if (got.read_value !== want.read_value)
                    $display("%0t: read_value expected %08h got %08h", $time,
                             want.read_value, got.read_value);
                if (got.insert_kind !== want.insert_kind)
                    $display("%0t: insert_kind expected %0d got %0d", $time,
                             want.insert_kind, got.insert_kind);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_resp resp;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_data, resp);
                expected_resp_q.push_back(resp);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_resp_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                        $display("%0t: unexpected response expected none got %h", $time,
                                 i_out_data);
                end else begin
                    resp = expected_resp_q.pop_front();
                    check_resp(resp, i_out_data);
                end
            end
            pending_count <= expected_resp_q.size();
        end
    end

endmodule

// ----- test/bucketed_hash_table_lfu_tb.sv -----
// Testbench top for the bucketed hash table: clock, reset, request stimulus, random
// back-pressure and the final verdict. Depends on bhl_pkg, the block and its checker.
module bucketed_hash_table_lfu_tb;
    import bhl_pkg::*;

    localparam int LOG2_BUCKETS = DEF_LOG2_BUCKETS;
    localparam int NUM_BUCKETS  = 1 << LOG2_BUCKETS;
    localparam int WINDOW_KEYS  = 40;
    localparam int WINDOW_SPAN  = 6;
    localparam int TWIN_KEYS    = 8;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOT_UPDATES  = 16;
    localparam logic [LOG2_BUCKETS-1:0] WINDOW_START = LOG2_BUCKETS'(NUM_BUCKETS - 3);

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_req  in_data   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_resp out_data;

    int idle_pct  = 0;
    int stall_pct = 0;
    int fail_count;
    int pending;

    logic [63:0] window_keys [WINDOW_KEYS];
    logic [63:0] twin_keys   [TWIN_KEYS];

    bucketed_hash_table_lfu #(
        .LOG2_BUCKETS(LOG2_BUCKETS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    bucketed_hash_table_lfu_check #(
        .LOG2_BUCKETS(LOG2_BUCKETS)
    ) u_table_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .o_errors   (fail_count),
        .o_pending  (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [LOG2_BUCKETS-1:0] home_bucket(input logic [63:0] k);
        logic [63:0] x;
        x = k ^ (k >> 33);
        x = x * MIX_C1;
        x = x ^ (x >> 33);
        x = x * MIX_C2;
        x = x ^ (x >> 33);
        return x[LOG2_BUCKETS-1:0];
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send(input logic cmd, input logic [63:0] k, input logic [31:0] v);
        t_req req;
        int   gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(30, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.command = cmd;
        req.key     = k;
        req.value   = v;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin : stimulus
        logic [63:0]             k;
        logic [LOG2_BUCKETS-1:0] off;
        logic                    cmd;
        int                      i;
        int                      n;
        int                      pick;

        n = 0;
        while (n < WINDOW_KEYS) begin
            k   = rand_key();
            off = home_bucket(k) - WINDOW_START;
            if (off < WINDOW_SPAN && k != EMPTY_KEY) begin
                window_keys[n] = k;
                n++;
            end
        end
        twin_keys[0] = rand_key();
        n = 1;
        while (n < TWIN_KEYS) begin
            k = rand_key();
            if (home_bucket(k) == home_bucket(twin_keys[0]) && k != EMPTY_KEY) begin
                twin_keys[n] = k;
                n++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send(CMD_LOOKUP, 64'd0, 32'hFFFF_FFFF);
        send(CMD_INSERT, 64'd0, 32'd0);
        send(CMD_LOOKUP, 64'd0, 32'd0);
        send(CMD_INSERT, 64'd0, 32'hFFFF_FFFF);
        send(CMD_LOOKUP, 64'd0, 32'd0);
        send(CMD_LOOKUP, EMPTY_KEY, 32'd0);
        send(CMD_INSERT, EMPTY_KEY, 32'hFFFF_FFFF);
        send(CMD_INSERT, EMPTY_KEY - 64'd1, 32'h8000_0000);
        send(CMD_LOOKUP, EMPTY_KEY - 64'd1, 32'd0);
        send(CMD_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555);
        send(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        for (i = 0; i < 5; i++) send(CMD_INSERT, twin_keys[i], $urandom);
        for (i = 0; i < 5; i++) send(CMD_LOOKUP, twin_keys[i], $urandom);

        // raise the first twin's use count, then crowd its bucket
        repeat (HOT_UPDATES) send(CMD_INSERT, twin_keys[0], $urandom);
        send(CMD_INSERT, twin_keys[5], $urandom);
        send(CMD_LOOKUP, twin_keys[0], 32'd0);
        send(CMD_INSERT, twin_keys[0], $urandom);
        send(CMD_INSERT, twin_keys[6], $urandom);
        send(CMD_LOOKUP, twin_keys[0], 32'd0);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            case (i / (RANDOM_ITEMS / 4))
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default: begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            cmd  = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_LOOKUP;
            pick = $urandom_range(99);
            if (pick < 70) begin
                k = window_keys[$urandom_range(WINDOW_KEYS - 1)];
            end else if (pick < 82) begin
                k = twin_keys[$urandom_range(TWIN_KEYS - 1)];
            end else if (pick < 96) begin
                k = rand_key();
            end else begin
                case ($urandom_range(2))
                    0:       k = 64'd0;
                    1:       k = EMPTY_KEY;
                    default: k = EMPTY_KEY - 64'd1;
                endcase
            end
            send(cmd, k, $urandom);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bhl_pkg.sv
rtl/core/bhl_ram.sv
rtl/core/bhl_hash.sv
rtl/core/bhl_bucket.sv
rtl/core/bucketed_hash_table_lfu.sv
test/bucketed_hash_table_lfu_check.sv
test/bucketed_hash_table_lfu_tb.sv
